### hdl/keyed_latency_histogram_assert.svh
// Assertion macros for the keyed latency histogram.
// Included by the top level; expects clk and rst_n in scope.
`ifndef KEYED_LATENCY_HISTOGRAM_ASSERT_SVH
`define KEYED_LATENCY_HISTOGRAM_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define KLH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define KLH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/klh_pkg.sv
// Package for the keyed latency histogram: sizes, codes, bucket bounds, states.
// No dependencies.
package klh_pkg;

    localparam int ENTRIES_DEF  = 32;
    localparam int NUM_BUCKETS  = 10;
    localparam int RESULT_LIMIT = 32;
    localparam int FREE_W       = 6;
    localparam int BKT_W        = 4;
    localparam int ROW_W        = 6;
    localparam int KEY_W        = 80;

    localparam logic CMD_REPORT  = 1'b0;
    localparam logic CMD_COLLECT = 1'b1;
    localparam logic KIND_ROW    = 1'b0;
    localparam logic KIND_FULL   = 1'b1;

    // Upper bounds of buckets 0..8, bucket 9 takes the rest
    localparam logic [31:0] BOUNDS [NUM_BUCKETS-1] = '{
        32'd5, 32'd10, 32'd20, 32'd50, 32'd100,
        32'd200, 32'd500, 32'd1000, 32'd2000
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KRD,
        ST_KCMP,
        ST_UPRD,
        ST_UPWR,
        ST_ALLOC,
        ST_CSCAN,
        ST_CRD,
        ST_COUT
    } state_t;

endpackage

### hdl/klh_if.sv
// Request and result channel interfaces for the keyed latency histogram.
// No dependencies.
interface klh_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] request_code;
    logic [31:0] cost;

    modport source (output valid, cmd, ip, port, request_code, cost, input ready);
    modport sink   (input valid, cmd, ip, port, request_code, cost, output ready);
endinterface

interface klh_rsp_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] ip_res;
    logic [15:0] port_res;
    logic [31:0] request_code_res;
    logic [63:0] counts_0_1;
    logic [63:0] counts_2_3;
    logic [63:0] counts_4_5;
    logic [63:0] counts_6_7;
    logic [63:0] counts_8_9;
    logic        last;

    modport source (output valid, kind, ip_res, port_res, request_code_res, counts_0_1,
                    counts_2_3, counts_4_5, counts_6_7, counts_8_9, last, input ready);
    modport sink   (input valid, kind, ip_res, port_res, request_code_res, counts_0_1,
                    counts_2_3, counts_4_5, counts_6_7, counts_8_9, last, output ready);
endinterface

### hdl/klh_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module klh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/klh_bucket_sel.sv
// Latency classifier: compares a cost against the bucket bounds.
// Depends on klh_pkg.
module klh_bucket_sel (
    input  logic [31:0]               cost,
    output logic [klh_pkg::BKT_W-1:0] bucket
);

    // Lowest bound that holds the cost wins
    always_comb
    begin
        bucket = klh_pkg::BKT_W'(klh_pkg::NUM_BUCKETS - 1);
        for (int k = klh_pkg::NUM_BUCKETS - 2; k >= 0; k--)
        begin
            if (cost <= klh_pkg::BOUNDS[k])
            begin
                bucket = klh_pkg::BKT_W'(k);
            end
        end
    end

endmodule

### hdl/keyed_latency_histogram.sv
// Keyed latency histogram, top level: sequencer, slot flags and the three RAMs.
// Depends on klh_pkg, klh_if, klh_ram, klh_bucket_sel and the assert header.
//
// One word is handled at a time; req.ready is high only while idle. A report
// scans the key RAM slot by slot (a key read, then a compare) until it hits,
// then does the counter read-modify-write, or writes the buckets of a newly
// allocated slot (one for the reported bucket, zero elsewhere). A table-full
// drop returns one word. A collect skips slots with no rows and, for each
// emitted row, reads and zeroes the ten buckets through the bucket RAM read
// and write ports, then waits for the output handshake. At most 32 rows per
// collect. No clearing pass after reset: slot valid and nonzero-total flags are flops.
module keyed_latency_histogram #(
    parameter int ENTRIES = klh_pkg::ENTRIES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    klh_req_if.sink   req,
    klh_rsp_if.source rsp
);

    localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int BDEPTH = ENTRIES * klh_pkg::NUM_BUCKETS;
    localparam int BA_W   = $clog2(BDEPTH);
    localparam int NB     = klh_pkg::NUM_BUCKETS;

    klh_pkg::state_t state_reg, state_next;

    logic [SLOT_W-1:0]          slot_reg, slot_next;
    logic [klh_pkg::BKT_W-1:0]  j_reg, j_next;
    logic [klh_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [klh_pkg::FREE_W-1:0] next_free_reg, next_free_next;
    logic [ENTRIES-1:0]         used_reg, used_next;
    logic [ENTRIES-1:0]         nz_reg, nz_next;

    // Request key and selected bucket
    logic [31:0]               kip_reg, kip_next;
    logic [15:0]               kport_reg, kport_next;
    logic [31:0]               kcode_reg, kcode_next;
    logic [klh_pkg::BKT_W-1:0] bsel_reg, bsel_next;

    // Output word
    logic        okind_reg, okind_next;
    logic        olast_reg, olast_next;
    logic [31:0] oip_reg, oip_next;
    logic [15:0] oport_reg, oport_next;
    logic [31:0] ocode_reg, ocode_next;
    logic [31:0] cnt_reg [NB];
    logic [31:0] cnt_next [NB];

    logic [klh_pkg::BKT_W-1:0] bucket;

    // RAM ports
    logic                      key_we;
    logic [SLOT_W-1:0]         key_waddr, key_raddr;
    logic [klh_pkg::KEY_W-1:0] key_wdata, key_rdata;
    logic                      tot_we;
    logic [SLOT_W-1:0]         tot_waddr, tot_raddr;
    logic [31:0]               tot_wdata, tot_rdata;
    logic                      bkt_we;
    logic [BA_W-1:0]           bkt_waddr, bkt_raddr;
    logic [31:0]               bkt_wdata, bkt_rdata;

    logic [BA_W-1:0] base;
    logic [31:0]     tot_inc;
    logic            any_above;
    logic            key_hit;
    logic            table_full;
    logic [SLOT_W-1:0] free_slot;

    klh_bucket_sel u_bucket_sel (
        .cost   (req.cost),
        .bucket (bucket)
    );

    klh_ram #(.WIDTH(klh_pkg::KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    klh_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_tot_ram (
        .clk   (clk),
        .we    (tot_we),
        .waddr (tot_waddr),
        .wdata (tot_wdata),
        .raddr (tot_raddr),
        .rdata (tot_rdata)
    );

    klh_ram #(.WIDTH(32), .DEPTH(BDEPTH)) u_bkt_ram (
        .clk   (clk),
        .we    (bkt_we),
        .waddr (bkt_waddr),
        .wdata (bkt_wdata),
        .raddr (bkt_raddr),
        .rdata (bkt_rdata)
    );

    // Slot base in the bucket RAM: slot * 10
    assign base = BA_W'((BA_W'(slot_reg) << 3) + (BA_W'(slot_reg) << 1));

    assign tot_inc    = tot_rdata + 32'd1;
    assign key_hit    = used_reg[slot_reg] && (key_rdata == {kip_reg, kport_reg, kcode_reg});
    assign table_full = (int'(next_free_reg) >= ENTRIES);
    assign free_slot  = next_free_reg[SLOT_W-1:0];

    // Any row-worthy slot above the current one
    always_comb
    begin
        any_above = 1'b0;
        for (int k = 0; k < ENTRIES; k++)
        begin
            if ((k > int'(slot_reg)) && used_reg[k] && nz_reg[k])
            begin
                any_above = 1'b1;
            end
        end
    end

    // Sequencer: next state, RAM strobes and register updates
    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        j_next         = j_reg;
        row_next       = row_reg;
        next_free_next = next_free_reg;
        used_next      = used_reg;
        nz_next        = nz_reg;
        kip_next       = kip_reg;
        kport_next     = kport_reg;
        kcode_next     = kcode_reg;
        bsel_next      = bsel_reg;
        okind_next     = okind_reg;
        olast_next     = olast_reg;
        oip_next       = oip_reg;
        oport_next     = oport_reg;
        ocode_next     = ocode_reg;
        cnt_next       = cnt_reg;

        key_we    = 1'b0;
        key_waddr = free_slot;
        key_wdata = {kip_reg, kport_reg, kcode_reg};
        key_raddr = slot_reg;
        tot_we    = 1'b0;
        tot_waddr = slot_reg;
        tot_wdata = tot_inc;
        tot_raddr = slot_reg;
        bkt_we    = 1'b0;
        bkt_waddr = base + BA_W'(bsel_reg);
        bkt_wdata = bkt_rdata + 32'd1;
        bkt_raddr = base + BA_W'(bsel_reg);

        req.ready = 1'b0;

        unique case (state_reg)
            klh_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    kip_next   = req.ip;
                    kport_next = req.port;
                    kcode_next = req.request_code;
                    bsel_next  = bucket;
                    slot_next  = '0;
                    row_next   = '0;
                    j_next     = '0;
                    if (req.cmd == klh_pkg::CMD_REPORT)
                    begin
                        state_next = klh_pkg::ST_KRD;
                    end
                    else
                    begin
                        state_next = klh_pkg::ST_CSCAN;
                    end
                end
            end

            klh_pkg::ST_KRD:
            begin
                state_next = klh_pkg::ST_KCMP;
            end

            klh_pkg::ST_KCMP:
            begin
                if (key_hit)
                begin
                    state_next = klh_pkg::ST_UPRD;
                end
                else if (slot_reg != SLOT_W'(ENTRIES - 1))
                begin
                    slot_next  = slot_reg + SLOT_W'(1);
                    state_next = klh_pkg::ST_KRD;
                end
                else if (table_full)
                begin
                    // Drop word: key of the report, zero counts
                    okind_next = klh_pkg::KIND_FULL;
                    olast_next = 1'b1;
                    oip_next   = kip_reg;
                    oport_next = kport_reg;
                    ocode_next = kcode_reg;
                    for (int k = 0; k < NB; k++)
                    begin
                        cnt_next[k] = '0;
                    end
                    state_next = klh_pkg::ST_COUT;
                end
                else
                begin
                    // Allocate the next free slot with total one
                    key_we              = 1'b1;
                    tot_we              = 1'b1;
                    tot_waddr           = free_slot;
                    tot_wdata           = 32'd1;
                    used_next[free_slot] = 1'b1;
                    nz_next[free_slot]   = 1'b1;
                    next_free_next      = next_free_reg + klh_pkg::FREE_W'(1);
                    slot_next           = free_slot;
                    j_next              = '0;
                    state_next          = klh_pkg::ST_ALLOC;
                end
            end

            klh_pkg::ST_ALLOC:
            begin
                bkt_we    = 1'b1;
                bkt_waddr = base + BA_W'(j_reg);
                bkt_wdata = (j_reg == bsel_reg) ? 32'd1 : 32'd0;
                if (j_reg == klh_pkg::BKT_W'(NB - 1))
                begin
                    state_next = klh_pkg::ST_IDLE;
                end
                else
                begin
                    j_next = j_reg + klh_pkg::BKT_W'(1);
                end
            end

            klh_pkg::ST_UPRD:
            begin
                state_next = klh_pkg::ST_UPWR;
            end

            klh_pkg::ST_UPWR:
            begin
                tot_we            = 1'b1;
                bkt_we            = 1'b1;
                nz_next[slot_reg] = (tot_inc != 32'd0);
                state_next        = klh_pkg::ST_IDLE;
            end

            klh_pkg::ST_CSCAN:
            begin
                if (used_reg[slot_reg] && nz_reg[slot_reg])
                begin
                    j_next     = '0;
                    state_next = klh_pkg::ST_CRD;
                end
                else if (slot_reg == SLOT_W'(ENTRIES - 1))
                begin
                    state_next = klh_pkg::ST_IDLE;
                end
                else
                begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
            end

            klh_pkg::ST_CRD:
            begin
                // Read bucket j, capture and zero bucket j-1 (at j = 0, capture the key)
                bkt_raddr = base + BA_W'(j_reg);
                if (j_reg == '0)
                begin
                    oip_next   = key_rdata[79:48];
                    oport_next = key_rdata[47:32];
                    ocode_next = key_rdata[31:0];
                end
                else
                begin
                    cnt_next[j_reg - klh_pkg::BKT_W'(1)] = bkt_rdata;
                    bkt_we    = 1'b1;
                    bkt_waddr = base + BA_W'(j_reg - klh_pkg::BKT_W'(1));
                    bkt_wdata = '0;
                end
                if (j_reg == klh_pkg::BKT_W'(NB))
                begin
                    okind_next = klh_pkg::KIND_ROW;
                    olast_next = (row_reg == klh_pkg::ROW_W'(klh_pkg::RESULT_LIMIT - 1))
                                 || !any_above;
                    state_next = klh_pkg::ST_COUT;
                end
                else
                begin
                    j_next = j_reg + klh_pkg::BKT_W'(1);
                end
            end

            klh_pkg::ST_COUT:
            begin
                if (rsp.ready)
                begin
                    if (okind_reg == klh_pkg::KIND_FULL || olast_reg)
                    begin
                        state_next = klh_pkg::ST_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + klh_pkg::ROW_W'(1);
                        slot_next  = slot_reg + SLOT_W'(1);
                        state_next = klh_pkg::ST_CSCAN;
                    end
                end
            end

            default:
            begin
                state_next = klh_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= klh_pkg::ST_IDLE;
            slot_reg      <= '0;
            j_reg         <= '0;
            row_reg       <= '0;
            next_free_reg <= '0;
            used_reg      <= '0;
            nz_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            j_reg         <= j_next;
            row_reg       <= row_next;
            next_free_reg <= next_free_next;
            used_reg      <= used_next;
            nz_reg        <= nz_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        kip_reg   <= kip_next;
        kport_reg <= kport_next;
        kcode_reg <= kcode_next;
        bsel_reg  <= bsel_next;
        okind_reg <= okind_next;
        olast_reg <= olast_next;
        oip_reg   <= oip_next;
        oport_reg <= oport_next;
        ocode_reg <= ocode_next;
        cnt_reg   <= cnt_next;
    end

    // Result word
    assign rsp.valid            = (state_reg == klh_pkg::ST_COUT);
    assign rsp.kind             = okind_reg;
    assign rsp.last             = olast_reg;
    assign rsp.ip_res           = oip_reg;
    assign rsp.port_res         = oport_reg;
    assign rsp.request_code_res = ocode_reg;
    assign rsp.counts_0_1       = {cnt_reg[1], cnt_reg[0]};
    assign rsp.counts_2_3       = {cnt_reg[3], cnt_reg[2]};
    assign rsp.counts_4_5       = {cnt_reg[5], cnt_reg[4]};
    assign rsp.counts_6_7       = {cnt_reg[7], cnt_reg[6]};
    assign rsp.counts_8_9       = {cnt_reg[9], cnt_reg[8]};

`include "keyed_latency_histogram_assert.svh"

    `KLH_ASSERT_NOW(a_no_accept_while_out, req.ready, !rsp.valid, "accept with word pending")
    `KLH_ASSERT_NOW(a_drop_is_last, rsp.valid && (rsp.kind == klh_pkg::KIND_FULL), rsp.last,
        "drop word not last")
    `KLH_ASSERT_NEXT(a_free_steps, 1'b1,
        (next_free_reg == $past(next_free_reg)) ||
        (next_free_reg == ($past(next_free_reg) + klh_pkg::FREE_W'(1))), "free pointer jump")

endmodule

### test/keyed_latency_histogram_tb.sv
// Testbench for keyed_latency_histogram: directed table, then random reports and collects.
// Depends on klh_pkg, klh_if and the top level; checks every result word against a predictor.
`timescale 1ns / 100ps

module keyed_latency_histogram_tb;

    localparam int SLOTS    = 32;
    localparam int POOL_N   = 40;
    localparam int PHASE_N  = 75;

    typedef struct {
        logic        kind;
        logic [31:0] ip;
        logic [15:0] port;
        logic [31:0] code;
        logic [63:0] counts [5];
        logic        last;
    } row_t;

    typedef struct {
        logic        cmd;
        logic [31:0] ip;
        logic [15:0] port;
        logic [31:0] code;
        logic [31:0] cost;
        bit          typed;     // expectation typed in: none at all
    } stim_t;

    logic clk;
    logic rst_n;

    klh_req_if req ();
    klh_rsp_if rsp ();

    keyed_latency_histogram dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Predicted table contents
    bit          tbl_used  [SLOTS];
    logic [31:0] tbl_ip    [SLOTS];
    logic [15:0] tbl_port  [SLOTS];
    logic [31:0] tbl_code  [SLOTS];
    logic [31:0] tbl_total [SLOTS];
    logic [31:0] tbl_bkt   [SLOTS][klh_pkg::NUM_BUCKETS];
    int          tbl_next;

    row_t        rows_due [$];
    int          errors;
    int          src_idle;
    int          snk_stall;

    logic [31:0] pool_ip   [POOL_N];
    logic [15:0] pool_port [POOL_N];
    logic [31:0] pool_code [POOL_N];

    // Directed words: empty collect after reset, every bucket edge, key extremes
    stim_t dir_tab [] = '{
        '{klh_pkg::CMD_COLLECT, 32'h0, 16'h0, 32'h0, 32'h0, 1'b1},
        '{klh_pkg::CMD_REPORT, '1, '1, '1, 32'd0, 1'b0},
        '{klh_pkg::CMD_REPORT, '1, '1, '1, 32'd5, 1'b0},
        '{klh_pkg::CMD_REPORT, '1, '1, '1, 32'd6, 1'b0},
        '{klh_pkg::CMD_REPORT, '1, '1, '1, 32'd10, 1'b0},
        '{klh_pkg::CMD_REPORT, '1, '1, '1, 32'd11, 1'b0},
        '{klh_pkg::CMD_REPORT, '1, '1, '1, 32'd20, 1'b0},
        '{klh_pkg::CMD_REPORT, '1, '1, '1, 32'd21, 1'b0},
        '{klh_pkg::CMD_REPORT, '1, '1, '1, 32'd50, 1'b0},
        '{klh_pkg::CMD_REPORT, '1, '1, '1, 32'd51, 1'b0},
        '{klh_pkg::CMD_REPORT, '1, '1, '1, 32'd100, 1'b0},
        '{klh_pkg::CMD_REPORT, '1, '1, '1, 32'd101, 1'b0},
        '{klh_pkg::CMD_REPORT, '1, '1, '1, 32'd200, 1'b0},
        '{klh_pkg::CMD_REPORT, '1, '1, '1, 32'd201, 1'b0},
        '{klh_pkg::CMD_REPORT, '1, '1, '1, 32'd500, 1'b0},
        '{klh_pkg::CMD_REPORT, '1, '1, '1, 32'd501, 1'b0},
        '{klh_pkg::CMD_REPORT, '1, '1, '1, 32'd1000, 1'b0},
        '{klh_pkg::CMD_REPORT, '1, '1, '1, 32'd1001, 1'b0},
        '{klh_pkg::CMD_REPORT, '1, '1, '1, 32'd2000, 1'b0},
        '{klh_pkg::CMD_REPORT, '1, '1, '1, 32'd2001, 1'b0},
        '{klh_pkg::CMD_REPORT, '1, '1, '1, 32'hFFFF_FFFF, 1'b0},
        '{klh_pkg::CMD_REPORT, 32'h0, 16'h0, 32'h0, 32'd7, 1'b0},
        '{klh_pkg::CMD_COLLECT, 32'h0, 16'h0, 32'h0, 32'h0, 1'b0},
        '{klh_pkg::CMD_COLLECT, 32'h0, 16'h0, 32'h0, 32'h0, 1'b0}
    };

    function automatic int bucket_of(logic [31:0] cost);
        for (int b = 0; b < klh_pkg::NUM_BUCKETS - 1; b++)
        begin
            if (cost <= klh_pkg::BOUNDS[b])
                return b;
        end
        return klh_pkg::NUM_BUCKETS - 1;
    endfunction

    // Update the predicted table for one accepted word, queue the rows it causes
    task automatic predict_word(stim_t s);
        int   hit;
        int   n;
        row_t r;
        hit = -1;
        n   = 0;
        if (s.cmd == klh_pkg::CMD_REPORT)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (hit < 0 && tbl_used[i] && tbl_ip[i] == s.ip && tbl_port[i] == s.port
                    && tbl_code[i] == s.code)
                    hit = i;
            end
            if (hit < 0 && tbl_next >= SLOTS)
            begin
                r.kind = klh_pkg::KIND_FULL;
                r.ip   = s.ip;
                r.port = s.port;
                r.code = s.code;
                foreach (r.counts[k])
                    r.counts[k] = '0;
                r.last = 1'b1;
                rows_due.push_back(r);
                return;
            end
            if (hit < 0)
            begin
                hit            = tbl_next;
                tbl_used[hit]  = 1'b1;
                tbl_ip[hit]    = s.ip;
                tbl_port[hit]  = s.port;
                tbl_code[hit]  = s.code;
                tbl_total[hit] = '0;
                for (int b = 0; b < klh_pkg::NUM_BUCKETS; b++)
                    tbl_bkt[hit][b] = '0;
                tbl_next++;
            end
            tbl_total[hit]++;
            tbl_bkt[hit][bucket_of(s.cost)]++;
        end
        else
        begin
            for (int i = 0; i < SLOTS && n < klh_pkg::RESULT_LIMIT; i++)
            begin
                if (tbl_used[i] && tbl_total[i] != 0)
                begin
                    r.kind = klh_pkg::KIND_ROW;
                    r.ip   = tbl_ip[i];
                    r.port = tbl_port[i];
                    r.code = tbl_code[i];
                    for (int k = 0; k < 5; k++)
                        r.counts[k] = {tbl_bkt[i][2*k+1], tbl_bkt[i][2*k]};
                    r.last = 1'b0;
                    for (int b = 0; b < klh_pkg::NUM_BUCKETS; b++)
                        tbl_bkt[i][b] = '0;
                    rows_due.push_back(r);
                    n++;
                end
            end
            if (n > 0)
                rows_due[rows_due.size() - 1].last = 1'b1;
        end
    endtask

    // Drive one word; valid stays high across back-to-back words
    task automatic send_word(stim_t s);
        if ($urandom_range(99) < src_idle)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle)
                @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.cmd          <= s.cmd;
        req.ip           <= s.ip;
        req.port         <= s.port;
        req.request_code <= s.code;
        req.cost         <= s.cost;
        do
            @(posedge clk);
        while (!req.ready);
        if (!s.typed)
            predict_word(s);
    endtask

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Result side: random stalls and checking of each word taken
    always @(posedge clk)
    begin
        row_t r;
        rsp.ready <= ($urandom_range(99) >= snk_stall);
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (rows_due.size() == 0)
            begin
                $display("%0t: unexpected result word, ip %h port %h", $time,
                         rsp.ip_res, rsp.port_res);
                errors++;
            end
            else
            begin
                r = rows_due.pop_front();
                check_field("kind", r.kind, rsp.kind);
                check_field("ip_res", r.ip, rsp.ip_res);
                check_field("port_res", r.port, rsp.port_res);
                check_field("request_code_res", r.code, rsp.request_code_res);
                check_field("counts_0_1", r.counts[0], rsp.counts_0_1);
                check_field("counts_2_3", r.counts[1], rsp.counts_2_3);
                check_field("counts_4_5", r.counts[2], rsp.counts_4_5);
                check_field("counts_6_7", r.counts[3], rsp.counts_6_7);
                check_field("counts_8_9", r.counts[4], rsp.counts_8_9);
                check_field("last", r.last, rsp.last);
            end
        end
    end

    // Stimulus
    initial
    begin
        stim_t s;
        int    p;
        int    edge_costs [10] = '{5, 10, 20, 50, 100, 200, 500, 1000, 2000, 0};
        errors           = 0;
        src_idle         = 0;
        snk_stall        = 0;
        tbl_next         = 0;
        foreach (tbl_used[i])
            tbl_used[i] = 1'b0;
        rst_n            = 1'b0;
        req.valid        = 1'b0;
        req.cmd          = klh_pkg::CMD_REPORT;
        req.ip           = '0;
        req.port         = '0;
        req.request_code = '0;
        req.cost         = '0;
        for (int i = 0; i < POOL_N; i++)
        begin
            pool_ip[i]   = $urandom;
            pool_port[i] = 16'($urandom);
            pool_code[i] = $urandom;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_word(dir_tab[i]);

        // Four phases: plain, idle source, stalled sink, both; key pool > table, so it fills
        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle  = (ph == 1 || ph == 3) ? ((ph == 1) ? 58 : 23) : 0;
            snk_stall = (ph == 2 || ph == 3) ? ((ph == 2) ? 58 : 23) : 0;
            for (int n = 0; n < PHASE_N; n++)
            begin
                s.typed = 1'b0;
                s.cmd   = ($urandom_range(99) < 9) ? klh_pkg::CMD_COLLECT : klh_pkg::CMD_REPORT;
                p       = $urandom_range(POOL_N - 1);
                if ($urandom_range(99) < 85)
                begin
                    s.ip   = pool_ip[p];
                    s.port = pool_port[p];
                    s.code = pool_code[p];
                end
                else
                begin
                    s.ip   = $urandom;
                    s.port = 16'($urandom);
                    s.code = $urandom;
                end
                if ($urandom_range(1))
                    s.cost = 32'(edge_costs[$urandom_range(9)] + $urandom_range(1));
                else
                    s.cost = $urandom;
                send_word(s);
            end
        end
        s = '{klh_pkg::CMD_COLLECT, 32'h0, 16'h0, 32'h0, 32'h0, 1'b0};
        send_word(s);
        req.valid <= 1'b0;

        while (rows_due.size() != 0)
            @(posedge clk);
        repeat (500) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
